@@ src/aco_pheromone_update_defines.svh @@
// Assertion macros used by the checker file of the pheromone update block.
`ifndef ACO_PHEROMONE_UPDATE_DEFINES_SVH
`define ACO_PHEROMONE_UPDATE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ACO_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ACO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/aco_pkg.sv @@
package aco_pkg;

    // Sizes of the matrices and of the path buffers.
    localparam int MAX_VERTICES = 64;
    localparam int MAX_PATH     = 128;

    localparam int VCW       = $clog2(MAX_VERTICES + 1);
    localparam int MAT_DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int MAT_AW    = $clog2(MAT_DEPTH);
    localparam int PATH_AW   = $clog2(MAX_PATH);
    localparam int PATH_LW   = $clog2(MAX_PATH + 1);

    // Field widths.
    localparam int ACTION_W   = 3;
    localparam int RC_W       = 6;
    localparam int DIST_W     = 16;
    localparam int VTX_W      = 6;
    localparam int IDX_W      = 7;
    localparam int COST_W     = 22;
    localparam int PHER_W     = 32;
    localparam int KEEP_W     = 16;
    localparam int AVG_W      = 24;
    localparam int VC_W       = 7;
    localparam int BLEN_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int PROD_W     = PHER_W + KEEP_W;

    // Divider: numerator is the Q16.8 average shifted up by 16 bits.
    localparam int DIV_NW = AVG_W + 16;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    // Input queue between front and back.
    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};
    localparam logic [PHER_W-1:0] PHER_INIT = 32'h0033_3333;
    localparam logic [PHER_W-1:0] PHER_MAX  = {PHER_W{1'b1}};

    // Action codes on the input port.
    localparam logic [ACTION_W-1:0] ACT_LOAD      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_VERTEX    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DECAY     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ_PHER = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ_BEST = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAP_KEEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_LEN      = 2'd2;

    localparam logic [VC_W-1:0]  VC_RESET   = 7'd64;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 16'd58982;
    localparam logic [AVG_W-1:0] AVG_RESET  = 24'd0;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_VERTEX,
        OP_DECAY,
        OP_READ_PHER,
        OP_READ_BEST,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [RC_W-1:0]   row;
        logic [RC_W-1:0]   col;
        logic [DIST_W-1:0] distance;
        logic [VTX_W-1:0]  vertex;
        logic              last;
        logic [IDX_W-1:0]  index;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } fe2bk_t;

    typedef struct packed {
        logic take;
        logic clearing;
    } bk2fe_t;

    typedef struct packed {
        logic [COST_W-1:0] path_cost;
        logic              zero_cost;
        logic              new_best;
        logic [COST_W-1:0] best_cost;
        logic [PHER_W-1:0] pheromone;
        logic [VTX_W-1:0]  best_vertex;
        logic [BLEN_W-1:0] best_length;
        logic              path_overflow;
    } res_t;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_LOAD,
        S_VTX,
        S_VADD,
        S_VFIN,
        S_DIV,
        S_E_START,
        S_E_P0,
        S_E_RDV,
        S_E_CAP,
        S_E_MUL,
        S_E_WR,
        S_D_START,
        S_D_RD,
        S_D_MUL,
        S_D_WR,
        S_RP,
        S_RP_W,
        S_BV,
        S_BV_W,
        S_RES
    } bk_state_t;

    // Flat matrix address of a (row, column) pair.
    function automatic logic [MAT_AW-1:0] mat_addr(input logic [VCW-1:0] r,
                                                   input logic [VCW-1:0] c);
        mat_addr = MAT_AW'(r) * MAT_AW'(MAX_VERTICES) + MAT_AW'(c);
    endfunction

endpackage

@@ src/aco_front.sv @@
module aco_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [aco_pkg::ACTION_W-1:0]   action,
    input  logic [aco_pkg::RC_W-1:0]       row,
    input  logic [aco_pkg::RC_W-1:0]       col,
    input  logic [aco_pkg::DIST_W-1:0]     distance,
    input  logic [aco_pkg::VTX_W-1:0]      vertex,
    input  logic                           last,
    input  logic [aco_pkg::IDX_W-1:0]      index,
    input  aco_pkg::bk2fe_t                bk,
    output aco_pkg::fe2bk_t                fe
);

    aco_pkg::item_t                  fq_mem_reg [aco_pkg::FQ_DEPTH];
    logic [aco_pkg::FQ_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [aco_pkg::FQ_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [aco_pkg::FQ_CW-1:0]       count_reg, count_next;
    aco_pkg::item_t                  in_item;
    logic                            accept;

    // Classify the incoming action into an operation.
    always_comb
    begin
        in_item.row      = row;
        in_item.col      = col;
        in_item.distance = distance;
        in_item.vertex   = vertex;
        in_item.last     = last;
        in_item.index    = index;
        case (action)
            aco_pkg::ACT_LOAD:      in_item.op = aco_pkg::OP_LOAD;
            aco_pkg::ACT_VERTEX:    in_item.op = aco_pkg::OP_VERTEX;
            aco_pkg::ACT_DECAY:     in_item.op = aco_pkg::OP_DECAY;
            aco_pkg::ACT_READ_PHER: in_item.op = aco_pkg::OP_READ_PHER;
            aco_pkg::ACT_READ_BEST: in_item.op = aco_pkg::OP_READ_BEST;
            default:                in_item.op = aco_pkg::OP_NONE;
        endcase
    end

    // The queue refuses items while the back end clears the pheromone store.
    assign full   = (count_reg == aco_pkg::FQ_CW'(aco_pkg::FQ_DEPTH)) || bk.clearing;
    assign accept = push && !full;

    assign fe.valid = (count_reg != '0);
    assign fe.item  = fq_mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == aco_pkg::FQ_AW'(aco_pkg::FQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (bk.take)
        begin
            rd_ptr_next = (rd_ptr_reg == aco_pkg::FQ_AW'(aco_pkg::FQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        case ({accept, bk.take})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fq_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ src/aco_div.sv @@
module aco_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [aco_pkg::DIV_NW-1:0]   num,
    input  logic [aco_pkg::COST_W-1:0]   den,
    output logic                         done,
    output logic [aco_pkg::DIV_NW-1:0]   quot
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [aco_pkg::DIV_CW-1:0]     cnt_reg, cnt_next;
    logic [aco_pkg::COST_W-1:0]     rem_reg, rem_next;
    logic [aco_pkg::COST_W-1:0]     den_reg, den_next;
    logic [aco_pkg::DIV_NW-1:0]     qr_reg, qr_next;
    logic [aco_pkg::COST_W:0]       shifted;
    logic [aco_pkg::COST_W:0]       diff;
    logic                           ge;

    // One restoring step per cycle, quotient bits shift in from the right.
    always_comb
    begin
        shifted   = {rem_reg, qr_reg[aco_pkg::DIV_NW-1]};
        ge        = shifted >= {1'b0, den_reg};
        diff      = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        qr_next   = qr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = den;
            qr_next   = num;
        end
        else if (busy_reg)
        begin
            qr_next  = {qr_reg[aco_pkg::DIV_NW-2:0], ge};
            rem_next = ge ? diff[aco_pkg::COST_W-1:0] : shifted[aco_pkg::COST_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == aco_pkg::DIV_CW'(aco_pkg::DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        qr_reg  <= qr_next;
    end

    assign done = done_reg;
    assign quot = qr_reg;

endmodule

@@ src/aco_back.sv @@
module aco_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  aco_pkg::fe2bk_t                  fe,
    output aco_pkg::bk2fe_t                  bk,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [aco_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aco_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                             empty,
    input  logic                             pop,
    output aco_pkg::res_t                    res
);

    localparam logic [aco_pkg::MAT_AW-1:0] CLR_LAST = aco_pkg::MAT_AW'(aco_pkg::MAT_DEPTH - 1);

    // Memories.
    logic [aco_pkg::DIST_W-1:0] dist_mem [aco_pkg::MAT_DEPTH];
    logic [aco_pkg::PHER_W-1:0] pher_mem [aco_pkg::MAT_DEPTH];
    logic [aco_pkg::VTX_W-1:0]  path_mem [2 ** (aco_pkg::PATH_AW + 1)];

    logic                           dist_we, dist_re;
    logic [aco_pkg::MAT_AW-1:0]     dist_addr;
    logic [aco_pkg::DIST_W-1:0]     dist_rd_reg;
    logic                           pher_we, pher_re;
    logic [aco_pkg::MAT_AW-1:0]     pher_addr;
    logic [aco_pkg::PHER_W-1:0]     pher_wdata;
    logic [aco_pkg::PHER_W-1:0]     pher_rd_reg;
    logic                           path_we, path_re;
    logic [aco_pkg::PATH_AW:0]      path_addr;
    logic [aco_pkg::VTX_W-1:0]      path_wdata;
    logic [aco_pkg::VTX_W-1:0]      path_rd_reg;

    aco_pkg::bk_state_t             state_reg, state_next;

    // Configuration.
    logic [aco_pkg::VC_W-1:0]       vc_reg, vc_next;
    logic [aco_pkg::KEEP_W-1:0]     keep_reg, keep_next;
    logic [aco_pkg::AVG_W-1:0]      avg_reg, avg_next;

    // Control state.
    logic [aco_pkg::MAT_AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [aco_pkg::PATH_LW-1:0]    len_reg, len_next;
    logic [aco_pkg::COST_W-1:0]     cost_reg, cost_next;
    logic                           over_reg, over_next;
    logic [aco_pkg::VTX_W-1:0]      prev_reg, prev_next;
    logic                           bank_reg, bank_next;
    logic [aco_pkg::COST_W-1:0]     best_cost_reg, best_cost_next;
    logic [aco_pkg::BLEN_W-1:0]     best_len_reg, best_len_next;
    logic                           out_valid_reg, out_valid_next;

    // Working registers of the item in progress.
    aco_pkg::item_t                 item_reg, item_next;
    logic                           walk_bank_reg, walk_bank_next;
    logic [aco_pkg::PATH_LW-1:0]    walk_len_reg, walk_len_next;
    logic [aco_pkg::PATH_LW-1:0]    i_reg, i_next;
    logic [aco_pkg::COST_W-1:0]     fin_cost_reg, fin_cost_next;
    logic [aco_pkg::PHER_W-1:0]     delta_reg, delta_next;
    logic [aco_pkg::VTX_W-1:0]      wprev_reg, wprev_next;
    logic [aco_pkg::MAT_AW-1:0]     edge_addr_reg, edge_addr_next;
    logic [aco_pkg::VCW-1:0]        r_reg, r_next;
    logic [aco_pkg::VCW-1:0]        c_reg, c_next;
    logic [aco_pkg::VCW-1:0]        n_reg, n_next;
    logic [aco_pkg::PROD_W-1:0]     prod_reg, prod_next;
    aco_pkg::res_t                  wres_reg, wres_next;
    aco_pkg::res_t                  out_reg, out_next;

    // Divider hookup and shared conditions.
    logic                           div_start, div_done;
    logic [aco_pkg::DIV_NW-1:0]     div_quot;
    logic                           rc_ok, vtx_ok, len_full, bv_ok, new_best;
    logic                           out_free;
    logic [aco_pkg::COST_W:0]       cost_sum;
    logic [aco_pkg::PHER_W:0]       dep_sum;
    logic [aco_pkg::PHER_W-1:0]     decayed;

    aco_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({avg_reg, 16'h0000}),
        .den   (cost_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign rc_ok    = (32'(item_reg.row) < aco_pkg::MAX_VERTICES) &&
                      (32'(item_reg.col) < aco_pkg::MAX_VERTICES);
    assign vtx_ok   = 32'(item_reg.vertex) < aco_pkg::MAX_VERTICES;
    assign len_full = 32'(len_reg) >= aco_pkg::MAX_PATH;
    assign bv_ok    = ({1'b0, item_reg.index} < best_len_reg) &&
                      (32'(item_reg.index) < aco_pkg::MAX_PATH);
    assign new_best = (cost_reg != '0) && (cost_reg < best_cost_reg);
    assign out_free = !out_valid_reg || pop;
    assign cost_sum = {1'b0, cost_reg} + (aco_pkg::COST_W + 1)'(dist_rd_reg);
    assign decayed  = prod_reg[aco_pkg::PROD_W-1:aco_pkg::KEEP_W];
    assign dep_sum  = {1'b0, decayed} +
                      ((fin_cost_reg != '0) ? {1'b0, delta_reg} : '0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            aco_pkg::S_CLR:
                if (clr_cnt_reg == CLR_LAST) state_next = aco_pkg::S_IDLE;
            aco_pkg::S_IDLE:
                if (fe.valid)
                begin
                    case (fe.item.op)
                        aco_pkg::OP_LOAD:      state_next = aco_pkg::S_LOAD;
                        aco_pkg::OP_VERTEX:    state_next = aco_pkg::S_VTX;
                        aco_pkg::OP_DECAY:     state_next = aco_pkg::S_D_START;
                        aco_pkg::OP_READ_PHER: state_next = aco_pkg::S_RP;
                        aco_pkg::OP_READ_BEST: state_next = aco_pkg::S_BV;
                        default:               state_next = aco_pkg::S_RES;
                    endcase
                end
            aco_pkg::S_LOAD:
                state_next = aco_pkg::S_RES;
            aco_pkg::S_VTX:
                state_next = (vtx_ok && !len_full && len_reg != '0) ?
                             aco_pkg::S_VADD : aco_pkg::S_VFIN;
            aco_pkg::S_VADD:
                state_next = aco_pkg::S_VFIN;
            aco_pkg::S_VFIN:
                if (!item_reg.last)        state_next = aco_pkg::S_RES;
                else if (cost_reg != '0)   state_next = aco_pkg::S_DIV;
                else                       state_next = aco_pkg::S_E_START;
            aco_pkg::S_DIV:
                if (div_done) state_next = aco_pkg::S_E_START;
            aco_pkg::S_E_START:
                state_next = (walk_len_reg < aco_pkg::PATH_LW'(2)) ?
                             aco_pkg::S_RES : aco_pkg::S_E_P0;
            aco_pkg::S_E_P0:
                state_next = aco_pkg::S_E_RDV;
            aco_pkg::S_E_RDV:
                state_next = (i_reg >= walk_len_reg) ? aco_pkg::S_RES : aco_pkg::S_E_CAP;
            aco_pkg::S_E_CAP:
                state_next = aco_pkg::S_E_MUL;
            aco_pkg::S_E_MUL:
                state_next = aco_pkg::S_E_WR;
            aco_pkg::S_E_WR:
                state_next = aco_pkg::S_E_RDV;
            aco_pkg::S_D_START:
                state_next = aco_pkg::S_D_RD;
            aco_pkg::S_D_RD:
                state_next = (r_reg >= n_reg) ? aco_pkg::S_RES : aco_pkg::S_D_MUL;
            aco_pkg::S_D_MUL:
                state_next = aco_pkg::S_D_WR;
            aco_pkg::S_D_WR:
                state_next = aco_pkg::S_D_RD;
            aco_pkg::S_RP:
                state_next = rc_ok ? aco_pkg::S_RP_W : aco_pkg::S_RES;
            aco_pkg::S_RP_W:
                state_next = aco_pkg::S_RES;
            aco_pkg::S_BV:
                state_next = bv_ok ? aco_pkg::S_BV_W : aco_pkg::S_RES;
            aco_pkg::S_BV_W:
                state_next = aco_pkg::S_RES;
            aco_pkg::S_RES:
                if (out_free) state_next = aco_pkg::S_IDLE;
            default:
                state_next = aco_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory controls and working register updates.
    always_comb
    begin
        dist_we    = 1'b0;
        dist_re    = 1'b0;
        dist_addr  = aco_pkg::mat_addr(aco_pkg::VCW'(item_reg.row),
                                       aco_pkg::VCW'(item_reg.col));
        pher_we    = 1'b0;
        pher_re    = 1'b0;
        pher_addr  = aco_pkg::mat_addr(aco_pkg::VCW'(item_reg.row),
                                       aco_pkg::VCW'(item_reg.col));
        pher_wdata = aco_pkg::PHER_INIT;
        path_we    = 1'b0;
        path_re    = 1'b0;
        path_addr  = {bank_reg, aco_pkg::PATH_AW'(len_reg)};
        path_wdata = item_reg.vertex;
        div_start  = 1'b0;
        bk.take    = 1'b0;
        bk.clearing = (state_reg == aco_pkg::S_CLR);

        clr_cnt_next   = clr_cnt_reg;
        len_next       = len_reg;
        cost_next      = cost_reg;
        over_next      = over_reg;
        prev_next      = prev_reg;
        bank_next      = bank_reg;
        best_cost_next = best_cost_reg;
        best_len_next  = best_len_reg;
        item_next      = item_reg;
        walk_bank_next = walk_bank_reg;
        walk_len_next  = walk_len_reg;
        i_next         = i_reg;
        fin_cost_next  = fin_cost_reg;
        delta_next     = delta_reg;
        wprev_next     = wprev_reg;
        edge_addr_next = edge_addr_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        n_next         = n_reg;
        prod_next      = prod_reg;
        wres_next      = wres_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;

        case (state_reg)
            // Fill the pheromone store with its start value after reset.
            aco_pkg::S_CLR:
            begin
                pher_we      = 1'b1;
                pher_addr    = clr_cnt_reg;
                pher_wdata   = aco_pkg::PHER_INIT;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            aco_pkg::S_IDLE:
            begin
                if (fe.valid)
                begin
                    bk.take   = 1'b1;
                    item_next = fe.item;
                    wres_next = '0;
                end
            end
            aco_pkg::S_LOAD:
            begin
                dist_we = rc_ok;
            end
            // Path vertex: fetch the edge length from the previous vertex; the first vertex is stored directly.
            aco_pkg::S_VTX:
            begin
                if (vtx_ok)
                begin
                    if (len_full)
                    begin
                        over_next = 1'b1;
                    end
                    else if (len_reg != '0)
                    begin
                        dist_re   = 1'b1;
                        dist_addr = aco_pkg::mat_addr(aco_pkg::VCW'(prev_reg),
                                                      aco_pkg::VCW'(item_reg.vertex));
                    end
                    else
                    begin
                        path_we   = 1'b1;
                        len_next  = len_reg + 1'b1;
                        prev_next = item_reg.vertex;
                    end
                end
            end
            aco_pkg::S_VADD:
            begin
                cost_next = cost_sum[aco_pkg::COST_W] ? aco_pkg::COST_MAX :
                            cost_sum[aco_pkg::COST_W-1:0];
                path_we   = 1'b1;
                len_next  = len_reg + 1'b1;
                prev_next = item_reg.vertex;
            end
            // End of path: best update, then the deposit and the edge walk.
            aco_pkg::S_VFIN:
            begin
                if (item_reg.last)
                begin
                    fin_cost_next           = cost_reg;
                    walk_len_next           = len_reg;
                    walk_bank_next          = bank_reg;
                    i_next                  = aco_pkg::PATH_LW'(1);
                    wres_next.path_cost     = cost_reg;
                    wres_next.zero_cost     = (cost_reg == '0);
                    wres_next.new_best      = new_best;
                    wres_next.path_overflow = over_reg;
                    if (new_best)
                    begin
                        best_cost_next = cost_reg;
                        best_len_next  = aco_pkg::BLEN_W'(len_reg);
                        bank_next      = !bank_reg;
                    end
                    div_start = (cost_reg != '0);
                    len_next  = '0;
                    cost_next = '0;
                    over_next = 1'b0;
                end
            end
            aco_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    delta_next = (div_quot[aco_pkg::DIV_NW-1:aco_pkg::PHER_W] != '0) ?
                                 aco_pkg::PHER_MAX : div_quot[aco_pkg::PHER_W-1:0];
                end
            end
            aco_pkg::S_E_START:
            begin
                path_re   = 1'b1;
                path_addr = {walk_bank_reg, aco_pkg::PATH_AW'(0)};
            end
            aco_pkg::S_E_P0:
            begin
                wprev_next = path_rd_reg;
            end
            aco_pkg::S_E_RDV:
            begin
                path_re   = 1'b1;
                path_addr = {walk_bank_reg, aco_pkg::PATH_AW'(i_reg)};
            end
            aco_pkg::S_E_CAP:
            begin
                edge_addr_next = aco_pkg::mat_addr(aco_pkg::VCW'(wprev_reg),
                                                   aco_pkg::VCW'(path_rd_reg));
                pher_re        = 1'b1;
                pher_addr      = aco_pkg::mat_addr(aco_pkg::VCW'(wprev_reg),
                                                   aco_pkg::VCW'(path_rd_reg));
                wprev_next     = path_rd_reg;
            end
            aco_pkg::S_E_MUL:
            begin
                prod_next = aco_pkg::PROD_W'(pher_rd_reg) * aco_pkg::PROD_W'(keep_reg);
            end
            aco_pkg::S_E_WR:
            begin
                pher_we    = 1'b1;
                pher_addr  = edge_addr_reg;
                pher_wdata = dep_sum[aco_pkg::PHER_W] ? aco_pkg::PHER_MAX :
                             dep_sum[aco_pkg::PHER_W-1:0];
                i_next     = i_reg + 1'b1;
            end
            // Decay of the whole active square, one entry at a time.
            aco_pkg::S_D_START:
            begin
                n_next = (32'(vc_reg) > aco_pkg::MAX_VERTICES) ?
                         aco_pkg::VCW'(aco_pkg::MAX_VERTICES) : aco_pkg::VCW'(vc_reg);
                r_next = '0;
                c_next = '0;
            end
            aco_pkg::S_D_RD:
            begin
                pher_re   = (r_reg < n_reg);
                pher_addr = aco_pkg::mat_addr(r_reg, c_reg);
            end
            aco_pkg::S_D_MUL:
            begin
                prod_next = aco_pkg::PROD_W'(pher_rd_reg) * aco_pkg::PROD_W'(keep_reg);
            end
            aco_pkg::S_D_WR:
            begin
                pher_we    = 1'b1;
                pher_addr  = aco_pkg::mat_addr(r_reg, c_reg);
                pher_wdata = decayed;
                if (c_reg + 1'b1 == n_reg)
                begin
                    c_next = '0;
                    r_next = r_reg + 1'b1;
                end
                else
                begin
                    c_next = c_reg + 1'b1;
                end
            end
            aco_pkg::S_RP:
            begin
                pher_re = rc_ok;
            end
            aco_pkg::S_RP_W:
            begin
                wres_next.pheromone = pher_rd_reg;
            end
            aco_pkg::S_BV:
            begin
                path_re   = bv_ok;
                path_addr = {!bank_reg, aco_pkg::PATH_AW'(item_reg.index)};
            end
            aco_pkg::S_BV_W:
            begin
                wres_next.best_vertex = path_rd_reg;
            end
            // Hand the result to the output register once it is free.
            aco_pkg::S_RES:
            begin
                if (out_free)
                begin
                    out_next             = wres_reg;
                    out_next.best_cost   = best_cost_reg;
                    out_next.best_length = best_len_reg;
                    out_valid_next       = 1'b1;
                end
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        vc_next   = vc_reg;
        keep_next = keep_reg;
        avg_next  = avg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                aco_pkg::CFG_VERTEX_COUNT: vc_next   = cfg_data[aco_pkg::VC_W-1:0];
                aco_pkg::CFG_EVAP_KEEP:    keep_next = cfg_data[aco_pkg::KEEP_W-1:0];
                aco_pkg::CFG_AVG_LEN:      avg_next  = cfg_data[aco_pkg::AVG_W-1:0];
                default:                   vc_next   = vc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aco_pkg::S_CLR;
            clr_cnt_reg   <= '0;
            len_reg       <= '0;
            cost_reg      <= '0;
            over_reg      <= 1'b0;
            bank_reg      <= 1'b0;
            best_cost_reg <= aco_pkg::COST_MAX;
            best_len_reg  <= '0;
            out_valid_reg <= 1'b0;
            vc_reg        <= aco_pkg::VC_RESET;
            keep_reg      <= aco_pkg::KEEP_RESET;
            avg_reg       <= aco_pkg::AVG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            len_reg       <= len_next;
            cost_reg      <= cost_next;
            over_reg      <= over_next;
            bank_reg      <= bank_next;
            best_cost_reg <= best_cost_next;
            best_len_reg  <= best_len_next;
            out_valid_reg <= out_valid_next;
            vc_reg        <= vc_next;
            keep_reg      <= keep_next;
            avg_reg       <= avg_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        prev_reg      <= prev_next;
        item_reg      <= item_next;
        walk_bank_reg <= walk_bank_next;
        walk_len_reg  <= walk_len_next;
        i_reg         <= i_next;
        fin_cost_reg  <= fin_cost_next;
        delta_reg     <= delta_next;
        wprev_reg     <= wprev_next;
        edge_addr_reg <= edge_addr_next;
        r_reg         <= r_next;
        c_reg         <= c_next;
        n_reg         <= n_next;
        prod_reg      <= prod_next;
        wres_reg      <= wres_next;
        out_reg       <= out_next;
    end

    // Distance store.
    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_addr] <= item_reg.distance;
        end
        if (dist_re)
        begin
            dist_rd_reg <= dist_mem[dist_addr];
        end
    end

    // Pheromone store.
    always_ff @(posedge clk)
    begin
        if (pher_we)
        begin
            pher_mem[pher_addr] <= pher_wdata;
        end
        if (pher_re)
        begin
            pher_rd_reg <= pher_mem[pher_addr];
        end
    end

    // Path buffers: one bank fills while the other holds the best path.
    always_ff @(posedge clk)
    begin
        if (path_we)
        begin
            path_mem[path_addr] <= path_wdata;
        end
        if (path_re)
        begin
            path_rd_reg <= path_mem[path_addr];
        end
    end

    assign empty = !out_valid_reg;
    assign res   = out_reg;

endmodule

@@ src/aco_pheromone_update.sv @@
// Channel   Direction  Handshake          Contents
// input     in         push / full        action, row, col, distance, vertex, last, index
// result    out        empty / pop        path_cost ... path_overflow, one per item
// config    in         cfg_valid / ready  cfg_index, cfg_data
//
// After reset the pheromone store, all 4096 entries, is filled with 0.2, with full held high.
// A final vertex adds a divide (when the cost is nonzero), walk setup and, for each edge,
// a read, a multiply and a write back; decay-all reads, multiplies and writes back each entry.
// A two-item input queue keeps accepting, until it is full, while a finished result waits to be popped.
module aco_pheromone_update (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [aco_pkg::ACTION_W-1:0]     action,
    input  logic [aco_pkg::RC_W-1:0]         row,
    input  logic [aco_pkg::RC_W-1:0]         col,
    input  logic [aco_pkg::DIST_W-1:0]       distance,
    input  logic [aco_pkg::VTX_W-1:0]        vertex,
    input  logic                             last,
    input  logic [aco_pkg::IDX_W-1:0]        index,
    output logic                             empty,
    input  logic                             pop,
    output logic [aco_pkg::COST_W-1:0]       path_cost,
    output logic                             zero_cost,
    output logic                             new_best,
    output logic [aco_pkg::COST_W-1:0]       best_cost,
    output logic [aco_pkg::PHER_W-1:0]       pheromone,
    output logic [aco_pkg::VTX_W-1:0]        best_vertex,
    output logic [aco_pkg::BLEN_W-1:0]       best_length,
    output logic                             path_overflow,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [aco_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [aco_pkg::CFG_DATA_W-1:0]   cfg_data
);

    aco_pkg::fe2bk_t fe;
    aco_pkg::bk2fe_t bk;
    aco_pkg::res_t   res;

    aco_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .action   (action),
        .row      (row),
        .col      (col),
        .distance (distance),
        .vertex   (vertex),
        .last     (last),
        .index    (index),
        .bk       (bk),
        .fe       (fe)
    );

    aco_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fe        (fe),
        .bk        (bk),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    // Result fields out to the ports.
    assign path_cost     = res.path_cost;
    assign zero_cost     = res.zero_cost;
    assign new_best      = res.new_best;
    assign best_cost     = res.best_cost;
    assign pheromone     = res.pheromone;
    assign best_vertex   = res.best_vertex;
    assign best_length   = res.best_length;
    assign path_overflow = res.path_overflow;

endmodule

@@ src/aco_checker.sv @@
`include "aco_pheromone_update_defines.svh"

module aco_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             empty,
    input logic                             pop,
    input logic [aco_pkg::COST_W-1:0]       path_cost,
    input logic                             zero_cost,
    input logic                             new_best,
    input logic [aco_pkg::COST_W-1:0]       best_cost,
    input logic [aco_pkg::PHER_W-1:0]       pheromone
);

    // A waiting result holds until it is popped.
    `ACO_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(path_cost) && $stable(best_cost) && $stable(pheromone), "waiting result changed")

    // A zero-cost path never becomes the best path.
    `ACO_ASSERT_IMP(a_zero, !empty && zero_cost, path_cost == '0 && !new_best, "zero cost path marked inconsistently")

    // A new best path reports its own cost as the best cost.
    `ACO_ASSERT_IMP(a_best, !empty && new_best, best_cost == path_cost && path_cost != '0, "new best cost mismatch")

    // The best cost never rises from one shown result to the next.
    `ACO_ASSERT_IMP(a_mono, !empty && $past(!empty), best_cost <= $past(best_cost), "best cost increased")

endmodule

bind aco_pheromone_update aco_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .path_cost (path_cost),
    .zero_cost (zero_cost),
    .new_best  (new_best),
    .best_cost (best_cost),
    .pheromone (pheromone)
);
